[sv/ei_input_shaper_seven_axis_macros.svh]
// Assertion helpers shared by the shaper modules.
`ifndef EI_INPUT_SHAPER_SEVEN_AXIS_MACROS_SVH
`define EI_INPUT_SHAPER_SEVEN_AXIS_MACROS_SVH

// Checked at every clock edge outside reset.
`define EIS_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("eis check failed: lbl");

// Checked also while reset is held.
`define EIS_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("eis check failed: lbl");

`endif

[sv/eis_pkg.sv]
package eis_pkg;

  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int JOINT_COUNT_DEF = 7;
  localparam int IO_JOINTS = 7;

  localparam int POS_W = 16;
  localparam int WHOLE_W = 7;
  localparam int FRAC_W = 16;
  localparam int GAIN_W = 17;
  localparam int COEF_W = 34;
  localparam int PROD_W = POS_W + COEF_W;
  localparam int ACC_W = 52;
  localparam int CFG_IDX_W = 3;
  localparam int TERM_W = 3;

  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(65536);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MID_WHOLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_FRAC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_WHOLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_FRAC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MID  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FAR  = 3'd6;

  // Terms of one shaped sample, taken one per cycle.
  localparam logic [TERM_W-1:0] TERM_NOW     = 3'd0;
  localparam logic [TERM_W-1:0] TERM_MID_NEW = 3'd1;
  localparam logic [TERM_W-1:0] TERM_MID_OLD = 3'd2;
  localparam logic [TERM_W-1:0] TERM_FAR_NEW = 3'd3;
  localparam logic [TERM_W-1:0] TERM_FAR_OLD = 3'd4;
  localparam logic [TERM_W-1:0] TERM_LAST    = TERM_FAR_OLD;

  typedef struct packed {
    logic              apply_wr;
    logic              load_fill;
    logic              sweep_clr;
    logic              sweep_wr;
    logic              issue;
    logic [TERM_W-1:0] term;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_full;
  } status_t;

endpackage

[sv/eis_ram.sv]
module eis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/eis_datapath.sv]
`include "ei_input_shaper_seven_axis_macros.svh"

module eis_datapath #(
  parameter int HISTORY_DEPTH = eis_pkg::HISTORY_DEPTH_DEF,
  parameter int JOINT_COUNT = eis_pkg::JOINT_COUNT_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  eis_pkg::cmd_t                                cmd,
  output eis_pkg::status_t                             status,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [eis_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [eis_pkg::GAIN_W-1:0]                   cfg_data,
  input  logic [eis_pkg::IO_JOINTS-1:0][eis_pkg::POS_W-1:0] pos_in,
  input  logic                                         out_stall,
  output logic                                         out_valid,
  output logic [eis_pkg::IO_JOINTS-1:0][eis_pkg::POS_W-1:0] shaped
);

  import eis_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int RW = JOINT_COUNT * POS_W;
  localparam int DELAY_CODES = 1 << WHOLE_W;

  typedef logic [DELAY_CODES-1:0][AW-1:0] mod_tab_t;

  // Whole delays reduced to the ring length, worked out at elaboration.
  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    for (int i = 0; i < DELAY_CODES; i++) begin
      tab[i] = AW'(i % HISTORY_DEPTH);
    end
    return tab;
  endfunction

  localparam mod_tab_t ModTab = build_mod_tab();

  function automatic logic [AW-1:0] back_index(logic [AW-1:0] from, logic [AW-1:0] d);
    logic [AW:0] s;
    s = {1'b0, from} + (AW+1)'(HISTORY_DEPTH) - {1'b0, d};
    if (s >= (AW+1)'(HISTORY_DEPTH)) begin
      s = s - (AW+1)'(HISTORY_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] older_index(logic [AW-1:0] n);
    return (n == '0) ? AW'(HISTORY_DEPTH - 1) : n - AW'(1);
  endfunction

  logic [WHOLE_W-1:0] mid_whole, far_whole;
  logic [FRAC_W-1:0]  mid_frac, far_frac;
  logic [GAIN_W-1:0]  gain_now, gain_mid, gain_far;

  logic [AW-1:0] wi, wi_next, sweep_addr;
  logic [RW-1:0] fill, row_in;
  logic [AW-1:0] mid_new, mid_old, far_new, far_old;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic [GAIN_W-1:0] weight, gain;
  logic [COEF_W-1:0] coef;
  logic              acc_en;
  logic [ACC_W-1:0]  acc [JOINT_COUNT];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_whole <= WHOLE_W'(1);
      mid_frac  <= '0;
      far_whole <= WHOLE_W'(2);
      far_frac  <= '0;
      gain_now  <= ONE_Q16;
      gain_mid  <= '0;
      gain_far  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MID_WHOLE: mid_whole <= cfg_data[WHOLE_W-1:0];
        CFG_MID_FRAC:  mid_frac  <= cfg_data[FRAC_W-1:0];
        CFG_FAR_WHOLE: far_whole <= cfg_data[WHOLE_W-1:0];
        CFG_FAR_FRAC:  far_frac  <= cfg_data[FRAC_W-1:0];
        CFG_GAIN_NOW:  gain_now  <= cfg_data;
        CFG_GAIN_MID:  gain_mid  <= cfg_data;
        CFG_GAIN_FAR:  gain_far  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lanes without an input field hold zero.
  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_row_in
    if (j < IO_JOINTS) begin : g_fed
      assign row_in[j*POS_W +: POS_W] = pos_in[j];
    end else begin : g_unfed
      assign row_in[j*POS_W +: POS_W] = '0;
    end
  end

  assign wi_next = (wi == AW'(HISTORY_DEPTH - 1)) ? '0 : wi + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wi         <= '0;
      sweep_addr <= '0;
      fill       <= '0;
    end else begin
      if (cmd.apply_wr) begin
        wi <= wi_next;
      end
      if (cmd.load_fill) begin
        fill <= row_in;
      end
      if (cmd.sweep_clr) begin
        sweep_addr <= '0;
      end else if (cmd.sweep_wr) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
    end
  end

  assign status.sweep_last = (sweep_addr == AW'(HISTORY_DEPTH - 1));
  assign status.out_full   = out_valid & out_stall;

  assign ram_we    = cmd.apply_wr | cmd.sweep_wr;
  assign ram_waddr = cmd.apply_wr ? wi_next : sweep_addr;
  assign ram_wdata = cmd.apply_wr ? row_in : fill;

  assign mid_new = back_index(wi, ModTab[mid_whole]);
  assign mid_old = older_index(mid_new);
  assign far_new = back_index(wi, ModTab[far_whole]);
  assign far_old = older_index(far_new);

  // Each term is one row times a weight folded with its gain.
  always_comb begin
    case (cmd.term)
      TERM_NOW: begin
        ram_raddr = wi;
        weight    = ONE_Q16;
        gain      = gain_now;
      end
      TERM_MID_NEW: begin
        ram_raddr = mid_new;
        weight    = ONE_Q16 - {1'b0, mid_frac};
        gain      = gain_mid;
      end
      TERM_MID_OLD: begin
        ram_raddr = mid_old;
        weight    = {1'b0, mid_frac};
        gain      = gain_mid;
      end
      TERM_FAR_NEW: begin
        ram_raddr = far_new;
        weight    = ONE_Q16 - {1'b0, far_frac};
        gain      = gain_far;
      end
      TERM_FAR_OLD: begin
        ram_raddr = far_old;
        weight    = {1'b0, far_frac};
        gain      = gain_far;
      end
      default: begin
        ram_raddr = wi;
        weight    = '0;
        gain      = '0;
      end
    endcase
  end

  eis_ram #(
    .WIDTH(RW),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.issue;
    end
    coef <= COEF_W'(weight) * COEF_W'(gain);
  end

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_lane
    logic [PROD_W-1:0] prod;
    assign prod = PROD_W'(ram_rdata[j*POS_W +: POS_W]) * PROD_W'(coef);
    always_ff @(posedge clk) begin
      if (cmd.apply_wr) begin
        acc[j] <= '0;
      end else if (acc_en) begin
        acc[j] <= acc[j] + ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  for (genvar j = 0; j < IO_JOINTS; j++) begin : g_out
    if (j < JOINT_COUNT) begin : g_live
      always_ff @(posedge clk) begin
        if (cmd.load_out) begin
          shaped[j] <= (acc[j][ACC_W-1:32+POS_W] != '0) ? {POS_W{1'b1}}
                                                       : acc[j][32 +: POS_W];
        end
      end
    end else begin : g_dead
      assign shaped[j] = '0;
    end
  end

  `EIS_CHECK(a_one_writer, !(cmd.apply_wr && cmd.sweep_wr))
  `EIS_CHECK(a_issue_accumulates, cmd.issue |=> acc_en)
  `EIS_CHECK(a_sweep_keeps_pointer, cmd.sweep_wr |=> $stable(wi))
  `EIS_CHECK(a_no_clear_while_summing, acc_en |-> !cmd.apply_wr)

endmodule

[sv/eis_controller.sv]
`include "ei_input_shaper_seven_axis_macros.svh"

module eis_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  input  eis_pkg::status_t status,
  output eis_pkg::cmd_t    cmd
);

  import eis_pkg::*;

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [TERM_W-1:0] term, term_next;
  logic              accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    state_next = state;
    term_next  = term;
    cmd        = '0;
    cmd.term   = term;
    case (state)
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && op) begin
          cmd.load_fill = 1'b1;
          cmd.sweep_clr = 1'b1;
          state_next    = ST_SWEEP;
        end else if (accept) begin
          cmd.apply_wr = 1'b1;
          term_next    = TERM_NOW;
          state_next   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        term_next = term + TERM_W'(1);
        if (term == TERM_LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // The result register may still hold an earlier request.
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      term  <= TERM_NOW;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  `EIS_CHECK(a_term_in_range, (state == ST_ISSUE) |-> (term <= TERM_LAST))
  `EIS_CHECK(a_apply_starts_terms, (accept && !op) |=> (state == ST_ISSUE && term == TERM_NOW))
  `EIS_CHECK(a_load_only_when_free, cmd.load_out |-> !status.out_full)
  `EIS_CHECK_ALWAYS(a_reset_sweeps, rst |=> (state == ST_SWEEP))

endmodule

[sv/ei_input_shaper_seven_axis.sv]
// Apply request: the result is loaded once the output is free; the next request follows it.
// The five history terms go one per cycle through the ring RAM's read port and lane multipliers.
// Prime request: no result; stall stays high while every row is written with the new positions.
// Reset (synchronous): a clearing pass writes zero to all HISTORY_DEPTH rows, stall high,
// configuration writes accepted throughout; registers return to their reset values.
module ei_input_shaper_seven_axis #(
  parameter int HISTORY_DEPTH = eis_pkg::HISTORY_DEPTH_DEF,
  parameter int JOINT_COUNT = eis_pkg::JOINT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [eis_pkg::POS_W-1:0]     position_0,
  input  logic [eis_pkg::POS_W-1:0]     position_1,
  input  logic [eis_pkg::POS_W-1:0]     position_2,
  input  logic [eis_pkg::POS_W-1:0]     position_3,
  input  logic [eis_pkg::POS_W-1:0]     position_4,
  input  logic [eis_pkg::POS_W-1:0]     position_5,
  input  logic [eis_pkg::POS_W-1:0]     position_6,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [eis_pkg::POS_W-1:0]     shaped_0,
  output logic [eis_pkg::POS_W-1:0]     shaped_1,
  output logic [eis_pkg::POS_W-1:0]     shaped_2,
  output logic [eis_pkg::POS_W-1:0]     shaped_3,
  output logic [eis_pkg::POS_W-1:0]     shaped_4,
  output logic [eis_pkg::POS_W-1:0]     shaped_5,
  output logic [eis_pkg::POS_W-1:0]     shaped_6,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [eis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eis_pkg::GAIN_W-1:0]    cfg_data
);

  import eis_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [IO_JOINTS-1:0][POS_W-1:0] pos_in;
  logic [IO_JOINTS-1:0][POS_W-1:0] shaped;

  assign pos_in = {position_6, position_5, position_4, position_3,
                   position_2, position_1, position_0};

  assign shaped_0 = shaped[0];
  assign shaped_1 = shaped[1];
  assign shaped_2 = shaped[2];
  assign shaped_3 = shaped[3];
  assign shaped_4 = shaped[4];
  assign shaped_5 = shaped[5];
  assign shaped_6 = shaped[6];

  eis_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op      (op),
    .status  (status),
    .cmd     (cmd)
  );

  eis_datapath #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .JOINT_COUNT  (JOINT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pos_in   (pos_in),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .shaped   (shaped)
  );

endmodule
